// ===== src/kle_pkg.sv =====
package kle_pkg;

    localparam int LINE_DEPTH = 64;
    localparam int PTR_W      = $clog2(LINE_DEPTH);
    localparam int CAP_W      = 7;
    localparam int BYTE_W     = 8;

    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int OUTQ_DEPTH = 2;
    localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);

    localparam logic [BYTE_W-1:0] KEY_ENTER  = 8'd13;
    localparam logic [BYTE_W-1:0] KEY_BACK   = 8'd8;
    localparam logic [BYTE_W-1:0] KEY_PREFIX = 8'd224;
    localparam logic [BYTE_W-1:0] EXT_HOME   = 8'd71;
    localparam logic [BYTE_W-1:0] EXT_LEFT   = 8'd75;
    localparam logic [BYTE_W-1:0] EXT_RIGHT  = 8'd77;
    localparam logic [BYTE_W-1:0] EXT_END    = 8'd79;
    localparam logic [BYTE_W-1:0] EXT_DELETE = 8'd83;

    typedef enum logic [3:0] {
        OP_CHAR,
        OP_ENTER,
        OP_BACK,
        OP_PREFIX,
        OP_HOME,
        OP_LEFT,
        OP_RIGHT,
        OP_END,
        OP_DELETE,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [BYTE_W-1:0] data;
    } cmd_t;

    typedef struct packed {
        logic [BYTE_W-1:0] line_byte;
        logic              last_of_run;
        logic              line_done;
        logic              beep;
        logic [PTR_W-1:0]  cursor_pos;
        logic [PTR_W-1:0]  line_length;
    } result_t;

endpackage

// ===== src/kle_front.sv =====
module kle_front
    import kle_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [BYTE_W-1:0] key_code,
    input  logic              key_waiting,
    output logic              cmd_valid,
    output cmd_t              cmd,
    input  logic              cmd_pop
);

    cmd_t                  q_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMDQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMDQ_PTR_W:0]   count_reg, count_next;
    logic                  pend_reg, pend_next;
    logic                  accept;
    logic                  take;
    cmd_t                  cls;

    assign full      = (count_reg == (CMDQ_PTR_W+1)'(CMDQ_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign accept    = push && !full;
    assign take      = cmd_pop && cmd_valid;

    // an extended code only follows a prefix taken while a key was waiting
    always_comb
    begin
        cls.data  = key_code;
        cls.op    = OP_CHAR;
        pend_next = pend_reg;
        if (accept)
        begin
            if (pend_reg)
            begin
                pend_next = 1'b0;
                case (key_code)
                    EXT_HOME:   cls.op = OP_HOME;
                    EXT_LEFT:   cls.op = OP_LEFT;
                    EXT_RIGHT:  cls.op = OP_RIGHT;
                    EXT_END:    cls.op = OP_END;
                    EXT_DELETE: cls.op = OP_DELETE;
                    default:    cls.op = OP_NOP;
                endcase
            end
            else if (key_code == KEY_ENTER)
            begin
                cls.op = OP_ENTER;
            end
            else if (key_code == KEY_BACK)
            begin
                cls.op = OP_BACK;
            end
            else if (key_code == KEY_PREFIX && key_waiting)
            begin
                cls.op    = OP_PREFIX;
                pend_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (accept)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (take)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (accept && !take)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (take && !accept)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            pend_reg   <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

// ===== src/kle_back.sv =====
module kle_back
    import kle_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [CAP_W-1:0] capacity,
    input  logic             cmd_valid,
    input  cmd_t             cmd,
    output logic             cmd_pop,
    input  logic             out_full,
    output logic             res_push,
    output result_t          res
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SHIFT  = 5'b00010,
        ST_STATUS = 5'b00100,
        ST_EMIT   = 5'b01000,
        ST_TERM   = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [PTR_W-1:0]  cursor_reg, cursor_next;
    logic [PTR_W-1:0]  length_reg, length_next;
    logic [PTR_W-1:0]  sh_idx_reg, sh_idx_next;
    logic [PTR_W-1:0]  em_idx_reg, em_idx_next;
    logic [PTR_W-1:0]  em_len_reg, em_len_next;

    logic [BYTE_W-1:0] mem [LINE_DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;
    logic              rd_en;
    logic [PTR_W-1:0]  rd_addr;
    logic              wr_en;
    logic [PTR_W-1:0]  wr_addr;
    logic [BYTE_W-1:0] wr_data;

    logic [CAP_W-1:0]  cap_m1;
    logic [CAP_W-1:0]  limit;
    logic              do_remove;
    logic [PTR_W-1:0]  rm_pos;
    logic              status_push;
    logic              status_beep;
    logic [PTR_W:0]    sh_ahead;
    logic [PTR_W:0]    em_ahead;

    // storable characters: capacity minus one, clamped to the store
    always_comb
    begin
        cap_m1 = capacity - 1'b1;
        if (capacity == '0)
        begin
            limit = '0;
        end
        else if (cap_m1 > CAP_W'(LINE_DEPTH - 1))
        begin
            limit = CAP_W'(LINE_DEPTH - 1);
        end
        else
        begin
            limit = cap_m1;
        end
    end

    assign sh_ahead = {1'b0, sh_idx_reg} + (PTR_W+1)'(2);
    assign em_ahead = {1'b0, em_idx_reg} + 1'b1;

    always_comb
    begin
        state_next  = state_reg;
        cursor_next = cursor_reg;
        length_next = length_reg;
        sh_idx_next = sh_idx_reg;
        em_idx_next = em_idx_reg;
        em_len_next = em_len_reg;
        cmd_pop     = 1'b0;
        res_push    = 1'b0;
        res         = '0;
        rd_en       = 1'b0;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = '0;
        do_remove   = 1'b0;
        rm_pos      = '0;
        status_push = 1'b0;
        status_beep = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.op)
                        OP_ENTER:
                        begin
                            cmd_pop     = 1'b1;
                            em_len_next = length_reg;
                            em_idx_next = '0;
                            cursor_next = '0;
                            length_next = '0;
                            if (length_reg == '0)
                            begin
                                state_next = ST_TERM;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                state_next = ST_EMIT;
                            end
                        end
                        OP_BACK:
                        begin
                            if (cursor_reg == '0)
                            begin
                                if (!out_full)
                                begin
                                    cmd_pop     = 1'b1;
                                    status_push = 1'b1;
                                    status_beep = 1'b1;
                                end
                            end
                            else
                            begin
                                cmd_pop     = 1'b1;
                                cursor_next = cursor_reg - 1'b1;
                                rm_pos      = cursor_reg - 1'b1;
                                do_remove   = 1'b1;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (cursor_reg >= length_reg)
                            begin
                                if (!out_full)
                                begin
                                    cmd_pop     = 1'b1;
                                    status_push = 1'b1;
                                    status_beep = 1'b1;
                                end
                            end
                            else
                            begin
                                cmd_pop   = 1'b1;
                                rm_pos    = cursor_reg;
                                do_remove = 1'b1;
                            end
                        end
                        default:
                        begin
                            if (!out_full)
                            begin
                                cmd_pop     = 1'b1;
                                status_push = 1'b1;
                                case (cmd.op)
                                    OP_CHAR:
                                    begin
                                        if (CAP_W'(cursor_reg) < limit)
                                        begin
                                            wr_en       = 1'b1;
                                            wr_addr     = cursor_reg;
                                            wr_data     = cmd.data;
                                            cursor_next = cursor_reg + 1'b1;
                                            if (cursor_reg >= length_reg)
                                            begin
                                                length_next = cursor_reg + 1'b1;
                                            end
                                        end
                                        else
                                        begin
                                            status_beep = 1'b1;
                                        end
                                    end
                                    OP_HOME:
                                    begin
                                        cursor_next = '0;
                                    end
                                    OP_LEFT:
                                    begin
                                        if (cursor_reg == '0)
                                        begin
                                            status_beep = 1'b1;
                                        end
                                        else
                                        begin
                                            cursor_next = cursor_reg - 1'b1;
                                        end
                                    end
                                    OP_RIGHT:
                                    begin
                                        if (cursor_reg >= length_reg)
                                        begin
                                            status_beep = 1'b1;
                                        end
                                        else
                                        begin
                                            cursor_next = cursor_reg + 1'b1;
                                        end
                                    end
                                    OP_END:
                                    begin
                                        cursor_next = length_reg;
                                    end
                                    default:
                                    begin
                                        cursor_next = cursor_reg;
                                    end
                                endcase
                            end
                        end
                    endcase
                end
            end
            ST_SHIFT:
            begin
                // data read last cycle moves down one place
                wr_en   = 1'b1;
                wr_addr = sh_idx_reg;
                wr_data = rd_data_reg;
                if (sh_ahead < {1'b0, length_reg})
                begin
                    rd_en       = 1'b1;
                    rd_addr     = sh_ahead[PTR_W-1:0];
                    sh_idx_next = sh_idx_reg + 1'b1;
                end
                else
                begin
                    length_next = length_reg - 1'b1;
                    state_next  = ST_STATUS;
                end
            end
            ST_STATUS:
            begin
                if (!out_full)
                begin
                    status_push = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (!out_full)
                begin
                    res_push      = 1'b1;
                    res.line_byte = rd_data_reg;
                    res.line_done = 1'b1;
                    if (em_ahead < {1'b0, em_len_reg})
                    begin
                        rd_en       = 1'b1;
                        rd_addr     = em_ahead[PTR_W-1:0];
                        em_idx_next = em_idx_reg + 1'b1;
                    end
                    else
                    begin
                        state_next = ST_TERM;
                    end
                end
            end
            ST_TERM:
            begin
                if (!out_full)
                begin
                    res_push        = 1'b1;
                    res.line_done   = 1'b1;
                    res.last_of_run = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // removal: nothing to move when the gap is the last byte
        if (do_remove)
        begin
            if ({1'b0, rm_pos} + 1'b1 >= {1'b0, length_reg})
            begin
                length_next = length_reg - 1'b1;
                state_next  = ST_STATUS;
            end
            else
            begin
                rd_en       = 1'b1;
                rd_addr     = rm_pos + 1'b1;
                sh_idx_next = rm_pos;
                state_next  = ST_SHIFT;
            end
        end

        if (status_push)
        begin
            res_push        = 1'b1;
            res.line_byte   = '0;
            res.last_of_run = 1'b1;
            res.line_done   = 1'b0;
            res.beep        = status_beep;
            res.cursor_pos  = cursor_next;
            res.line_length = length_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cursor_reg <= '0;
            length_reg <= '0;
            sh_idx_reg <= '0;
            em_idx_reg <= '0;
            em_len_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cursor_reg <= cursor_next;
            length_reg <= length_next;
            sh_idx_reg <= sh_idx_next;
            em_idx_reg <= em_idx_next;
            em_len_reg <= em_len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

// ===== src/kle_outq.sv =====
module kle_outq
    import kle_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    res_push,
    input  result_t res,
    output logic    out_full,
    output logic    empty,
    input  logic    pop,
    output result_t head
);

    result_t               q_reg [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OUTQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OUTQ_PTR_W:0]   count_reg, count_next;
    logic                  put;
    logic                  take;

    assign out_full = (count_reg == (OUTQ_PTR_W+1)'(OUTQ_DEPTH));
    assign empty    = (count_reg == '0);
    assign head     = q_reg[rd_ptr_reg];
    assign put      = res_push && !out_full;
    assign take     = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (put)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (take)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (put && !take)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (take && !put)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (put)
        begin
            q_reg[wr_ptr_reg] <= res;
        end
    end

endmodule

// ===== src/keystroke_line_editor_unit.sv =====
// a key request is held in the command queue; its status result passes through the result queue
// throughput, while the result queue has room: one editing key per cycle, and for enter length
// plus one results, one per cycle; a removal by backspace or delete shifts later bytes down first
// rate is bounded by the single read port of the line store and by room in the result queue
// reset: rst_n clears cursor, length, prefix state and both queues; capacity returns to 64
// the line store itself is not cleared; only bytes below the length are ever read
module keystroke_line_editor_unit
    import kle_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [BYTE_W-1:0]  key_code,
    input  logic               key_waiting,
    output logic               empty,
    input  logic               pop,
    output logic [BYTE_W-1:0]  line_byte,
    output logic               last_of_run,
    output logic               line_done,
    output logic               beep,
    output logic [PTR_W-1:0]   cursor_pos,
    output logic [PTR_W-1:0]   line_length,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CAP_W-1:0]   cfg_data
);

    logic [CAP_W-1:0] capacity_reg, capacity_next;
    logic             cmd_valid;
    cmd_t             cmd;
    logic             cmd_pop;
    logic             out_full;
    logic             res_push;
    result_t          res;
    result_t          head;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        capacity_next = capacity_reg;
        if (cfg_valid && cfg_ready)
        begin
            capacity_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_W'(LINE_DEPTH);
        end
        else
        begin
            capacity_reg <= capacity_next;
        end
    end

    kle_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .key_code    (key_code),
        .key_waiting (key_waiting),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop)
    );

    kle_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .capacity  (capacity_reg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .out_full  (out_full),
        .res_push  (res_push),
        .res       (res)
    );

    kle_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res      (res),
        .out_full (out_full),
        .empty    (empty),
        .pop      (pop),
        .head     (head)
    );

    assign line_byte   = head.line_byte;
    assign last_of_run = head.last_of_run;
    assign line_done   = head.line_done;
    assign beep        = head.beep;
    assign cursor_pos  = head.cursor_pos;
    assign line_length = head.line_length;

endmodule

// ===== src/kle_checker.sv =====
module kle_checker
    import kle_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              empty,
    input logic [BYTE_W-1:0] line_byte,
    input logic              last_of_run,
    input logic              line_done,
    input logic              beep,
    input logic [PTR_W-1:0]  cursor_pos,
    input logic [PTR_W-1:0]  line_length
);

    // nothing waits to be taken once reset has been sampled low
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
        else $error("result queue not empty in reset");

    // results of an enter report the cleared line
    a_line_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && line_done) |-> (cursor_pos == '0 && line_length == '0))
        else $error("line result with nonzero cursor or length");

    // a beep comes only on a status result, which closes its run
    a_beep_status: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && beep) |-> (last_of_run && !line_done))
        else $error("beep on a line result");

    // status results carry no byte and close their run
    a_status_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !line_done) |-> (line_byte == '0 && last_of_run))
        else $error("malformed status result");

    // the cursor never passes the end of the line
    a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (cursor_pos <= line_length))
        else $error("cursor beyond line length");

endmodule

bind keystroke_line_editor_unit kle_checker u_kle_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .empty       (empty),
    .line_byte   (line_byte),
    .last_of_run (last_of_run),
    .line_done   (line_done),
    .beep        (beep),
    .cursor_pos  (cursor_pos),
    .line_length (line_length)
);
